// ===== sv/sgr_pkg.sv =====
package sgr_pkg;

   // Character codes
   localparam logic [7:0] ESC_BYTE      = 8'h1B;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_M        = 8'h6D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   // Accumulator and attribute constants
   localparam int unsigned PARAM_WIDTH = 10;
   localparam int unsigned ACC_WIDTH   = 14;
   localparam logic [PARAM_WIDTH-1:0] ACC_MAX    = 10'd1023;
   localparam logic [ACC_WIDTH-1:0]   DEC_RADIX  = 14'd10;
   localparam logic [7:0]             ATTR_RESET = 8'h07;
   localparam logic [3:0]             BG_RED_INT = 4'hC;

   // SGR parameter codes
   localparam logic [PARAM_WIDTH-1:0] SGR_RESET   = 10'd0;
   localparam logic [PARAM_WIDTH-1:0] SGR_REVERSE = 10'd7;
   localparam logic [PARAM_WIDTH-1:0] SGR_FG_LO   = 10'd31;
   localparam logic [PARAM_WIDTH-1:0] SGR_FG_HI   = 10'd37;
   localparam logic [PARAM_WIDTH-1:0] SGR_BG_RED  = 10'd41;

   typedef enum logic [1:0] {
      MODE_TEXT  = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_PARAM = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] attr;
      logic       rev;
   } attr_state_type;

   // One result beat from the parser core
   typedef struct packed {
      logic       emit;
      logic [7:0] out_byte;
      logic [7:0] attribute;
   } sgr_result_type;

   // Foreground codes for 31..37, indexed by the low three bits of (v - 31)
   function automatic logic [3:0] fg_code(input logic [2:0] idx);
      logic [3:0] code;
      case (idx)
         3'd0:    code = 4'hC;
         3'd1:    code = 4'hA;
         3'd2:    code = 4'hE;
         3'd3:    code = 4'h9;
         3'd4:    code = 4'hD;
         3'd5:    code = 4'hB;
         default: code = 4'hF;
      endcase
      return code;
   endfunction

   // Apply one finished parameter to the stored attribute
   function automatic attr_state_type apply_param(input attr_state_type cur,
                                                  input logic [PARAM_WIDTH-1:0] v);
      attr_state_type           nxt;
      logic [PARAM_WIDTH-1:0]   off;
      nxt = cur;
      off = v - SGR_FG_LO;
      if (v == SGR_RESET) begin
         nxt.attr = ATTR_RESET;
         nxt.rev  = 1'b0;
      end else if (v == SGR_REVERSE) begin
         nxt.rev = 1'b1;
      end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
         nxt.attr = {cur.attr[7:4], fg_code(off[2:0])};
      end else if (v == SGR_BG_RED) begin
         nxt.attr = {BG_RED_INT, cur.attr[3:0]};
      end
      return nxt;
   endfunction

   // Attribute as seen on the console, nibbles swapped in reverse video
   function automatic logic [7:0] effective_attr(input attr_state_type st);
      return st.rev ? {st.attr[3:0], st.attr[7:4]} : st.attr;
   endfunction

endpackage

// ===== sv/sgr_core.sv =====
module sgr_core
   import sgr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_valid,
   input  logic [7:0]     step_byte,
   input  logic           step_last,
   output sgr_result_type step_result
);

   mode_type               mode_ff,  mode_in;
   logic [PARAM_WIDTH-1:0] param_ff, param_in;
   attr_state_type         st_ff,    st_in;

   logic                   is_digit;
   logic [ACC_WIDTH-1:0]   acc_sum;

   assign is_digit = (step_byte >= CHAR_ZERO) && (step_byte <= CHAR_NINE);
   assign acc_sum  = {{(ACC_WIDTH-PARAM_WIDTH){1'b0}}, param_ff} * DEC_RADIX
                   + {{(ACC_WIDTH-8){1'b0}}, step_byte - CHAR_ZERO};

   // Next parser state and result for one byte
   always_comb begin
      mode_in     = mode_ff;
      param_in    = param_ff;
      st_in       = st_ff;
      step_result = '0;
      step_result.out_byte = step_byte;

      unique case (mode_ff)
         MODE_ESC, MODE_PARAM: begin
            if (mode_ff == MODE_ESC && step_byte == CHAR_LBRACKET) begin
               mode_in = MODE_PARAM;
            end else if (is_digit) begin
               mode_in  = MODE_PARAM;
               param_in = (acc_sum > {{(ACC_WIDTH-PARAM_WIDTH){1'b0}}, ACC_MAX}) ?
                          ACC_MAX : acc_sum[PARAM_WIDTH-1:0];
            end else begin
               st_in    = apply_param(st_ff, param_ff);
               param_in = '0;
               if (step_byte == CHAR_SEMI) begin
                  mode_in = MODE_PARAM;
               end else if (step_byte == CHAR_M) begin
                  mode_in = MODE_TEXT;
               end else if (step_byte == ESC_BYTE) begin
                  mode_in = MODE_ESC;
               end else begin
                  mode_in               = MODE_TEXT;
                  step_result.emit      = 1'b1;
                  step_result.attribute = effective_attr(st_in);
               end
            end
         end
         default: begin
            // text mode, and the unused code behaves the same
            if (step_byte == ESC_BYTE) begin
               mode_in  = MODE_ESC;
               param_in = '0;
            end else begin
               mode_in               = MODE_TEXT;
               step_result.emit      = 1'b1;
               step_result.attribute = effective_attr(st_ff);
            end
         end
      endcase

      // last byte of a buffer closes an open sequence
      if (step_last && mode_in != MODE_TEXT) begin
         st_in    = apply_param(st_in, param_in);
         param_in = '0;
         mode_in  = MODE_TEXT;
      end

      if (!step_valid) begin
         step_result.emit = 1'b0;
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TEXT;
         param_ff    <= '0;
         st_ff.attr  <= ATTR_RESET;
         st_ff.rev   <= 1'b0;
      end else if (step_valid) begin
         mode_ff  <= mode_in;
         param_ff <= param_in;
         st_ff    <= st_in;
      end
   end

endmodule

// ===== sv/ansi_sgr_color_parser.sv =====
// Channel  | Direction | Ports                               | Handshake
// request  | in        | req_in_byte, req_last               | req_valid / req_ready
// response | out       | rsp_out_byte, rsp_attribute         | rsp_valid / rsp_ready
//
// One byte per cycle sustained while the response side is not stalled; the
// input register takes a byte's beat, and parser logic then loads its result
// into the output register.
// Escape, the '[' right after it, digits, ';' and a closing 'm' produce no response beat.
// Synchronous active-high reset: text mode, attribute 0x07, reverse off.
// A stalled response holds the parser stage; req_ready drops only while both
// stages are full and rsp_ready is low.
module ansi_sgr_color_parser
   import sgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_attribute
);

   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_last_ff;
   logic           s1_fire;
   logic           out_free;
   sgr_result_type core_result;

   logic           rsp_valid_ff;
   logic [7:0]     rsp_byte_ff;
   logic [7:0]     rsp_attr_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_in_byte;
         s1_last_ff <= req_last;
      end
   end

   sgr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (s1_fire),
      .step_byte   (s1_byte_ff),
      .step_last   (s1_last_ff),
      .step_result (core_result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= core_result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (core_result.emit && out_free) begin
         rsp_byte_ff <= core_result.out_byte;
         rsp_attr_ff <= core_result.attribute;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_attribute = rsp_attr_ff;

endmodule

// ===== sv/sgr_checker.sv =====
module sgr_checker
   import sgr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_attribute
);

   // A stalled request beat holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte) && $stable(req_last))
      else $error("request beat changed while stalled");

   // A stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_attribute))
      else $error("response beat changed while stalled");

   // Escape bytes always open a sequence and are never passed through
   a_no_esc_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte != ESC_BYTE)
      else $error("escape byte on response channel");

   // Backpressure only comes from a stalled response
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response backpressure");

   // No response beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind ansi_sgr_color_parser sgr_checker u_sgr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_in_byte   (req_in_byte),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_attribute (rsp_attribute)
);

// ===== sim/tb_ansi_sgr_color_parser.sv =====
`timescale 1ns / 100ps

module tb_ansi_sgr_color_parser;
   import sgr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_attribute;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] attr;
   } char_beat_type;

   // Predicts the console characters and their attributes, checks output beats
   class sgr_scoreboard;
      mode_type      mode;
      logic [9:0]    acc;
      logic [7:0]    attr;
      logic          rev;
      char_beat_type char_q[$];
      int            errors;

      function new();
         mode   = MODE_TEXT;
         acc    = '0;
         attr   = ATTR_RESET;
         rev    = 1'b0;
         errors = 0;
      endfunction

      function void apply_sgr(logic [9:0] v);
         logic [27:0] fg_nibbles;
         int          off;
         fg_nibbles = 28'hFBD9EAC;   // 31..37 foregrounds, lowest nibble first
         off        = int'(v) - int'(SGR_FG_LO);
         if (v == SGR_RESET) begin
            attr = ATTR_RESET;
            rev  = 1'b0;
         end else if (v == SGR_REVERSE) begin
            rev = 1'b1;
         end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
            attr[3:0] = fg_nibbles[off*4 +: 4];
         end else if (v == SGR_BG_RED) begin
            attr[7:4] = BG_RED_INT;
         end
      endfunction

      function logic [7:0] shown_attr();
         return rev ? {attr[3:0], attr[7:4]} : attr;
      endfunction

      // Accepted request beat: advance the parser and queue any char it prints
      function void note_byte(logic [7:0] b, logic l);
         int nv;
         bit emit;
         emit = 1'b0;
         if (mode == MODE_ESC && b == CHAR_LBRACKET) begin
            mode = MODE_PARAM;
         end else if (mode == MODE_ESC || mode == MODE_PARAM) begin
            mode = MODE_PARAM;
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               nv  = int'(acc) * 10 + int'(b - CHAR_ZERO);
               acc = (nv > int'(ACC_MAX)) ? ACC_MAX : nv[9:0];
            end else begin
               apply_sgr(acc);
               acc = '0;
               if (b == CHAR_M) begin
                  mode = MODE_TEXT;
               end else if (b == ESC_BYTE) begin
                  mode = MODE_ESC;
               end else if (b != CHAR_SEMI) begin
                  mode = MODE_TEXT;
                  emit = 1'b1;
               end
            end
         end else begin
            if (b == ESC_BYTE) begin
               mode = MODE_ESC;
               acc  = '0;
            end else begin
               mode = MODE_TEXT;
               emit = 1'b1;
            end
         end
         if (emit) char_q.push_back('{b, shown_attr()});
         // last byte of a buffer closes whatever sequence is still open
         if (l && mode != MODE_TEXT) begin
            apply_sgr(acc);
            acc  = '0;
            mode = MODE_TEXT;
         end
      endfunction

      function void check_beat(logic [7:0] ch, logic [7:0] at);
         char_beat_type exp_beat;
         if (char_q.size() == 0) begin
            $display("%0t: unexpected beat, actual byte %02h attr %02h", $time, ch, at);
            errors++;
         end else begin
            exp_beat = char_q.pop_front();
            if (ch !== exp_beat.ch) begin
               $display("%0t: out_byte mismatch, expected %02h actual %02h",
                        $time, exp_beat.ch, ch);
               errors++;
            end
            if (at !== exp_beat.attr) begin
               $display("%0t: attribute mismatch, expected %02h actual %02h",
                        $time, exp_beat.attr, at);
               errors++;
            end
         end
      endfunction

      function int pending();
         return char_q.size();
      endfunction
   endclass

   sgr_scoreboard sb;
   int            sent_count;
   int            cycle_count;
   int            send_idle;
   int            rsp_idle;
   bit            hold_req;
   logic [7:0]    seq_bytes[$];

   ansi_sgr_color_parser u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_attribute (rsp_attribute)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Beat monitor and run timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_in_byte, req_last);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_out_byte, rsp_attribute);
      end
   end

   // Response side: random ready, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   // One request beat; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_last    <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_seq_bytes(input bit close_last);
      for (int i = 0; i < seq_bytes.size(); i++)
         send_byte(seq_bytes[i], close_last && (i == seq_bytes.size() - 1));
      seq_bytes.delete();
   endtask

   // Escape sequence with random parameters and terminator
   task automatic send_random_sequence();
      int    n;
      int    v;
      int    r;
      string s;
      bit    close_last;
      seq_bytes.push_back(ESC_BYTE);
      if ($urandom_range(99) < 90) seq_bytes.push_back(CHAR_LBRACKET);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 15)      v = 0;
         else if (r < 30) v = 7;
         else if (r < 60) v = $urandom_range(31, 37);
         else if (r < 72) v = 41;
         else if (r < 80) v = -1;   // empty parameter
         else if (r < 92) v = $urandom_range(0, 99);
         else             v = $urandom_range(100, 99999);
         if (v >= 0) begin
            if ($urandom_range(99) < 10) seq_bytes.push_back(CHAR_ZERO);
            s = $sformatf("%0d", v);
            for (int j = 0; j < s.len(); j++) seq_bytes.push_back(s[j]);
         end
         if (i < n - 1) seq_bytes.push_back(CHAR_SEMI);
      end
      // terminator, or leave the sequence open and close it with last
      r = $urandom_range(99);
      close_last = 1'b0;
      if (r < 65)      seq_bytes.push_back(CHAR_M);
      else if (r < 75) seq_bytes.push_back(ESC_BYTE);
      else if (r < 88) seq_bytes.push_back(8'($urandom_range(255)));
      else             close_last = 1'b1;
      if ($urandom_range(99) < 5) close_last = 1'b1;
      send_seq_bytes(close_last);
   endtask

   task automatic run_random(input int upto);
      int pick;
      while (sent_count < upto) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
         end else if (pick < 85) begin
            send_random_sequence();
         end else begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      req_last    = 1'b0;
      send_idle   = 0;
      rsp_idle    = 0;
      hold_req    = 1'b0;
      sent_count  = 0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, SGR codes 37, 41, 7, 0 and 32, the corner cases
      send_idle = 23;
      rsp_idle  = 75;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      seq_bytes = '{ESC_BYTE, CHAR_LBRACKET, "3", "7", CHAR_SEMI, "4", "1", CHAR_M};
      send_seq_bytes(1'b0);
      // no '[' after escape: digit starts the list, 'Z' ends it and prints
      seq_bytes = '{ESC_BYTE, "7", "Z"};
      send_seq_bytes(1'b0);
      // empty parameter resets
      seq_bytes = '{ESC_BYTE, CHAR_LBRACKET, CHAR_M};
      send_seq_bytes(1'b0);
      // saturating number, escape as terminator, open sequence closed by last
      seq_bytes = '{ESC_BYTE, CHAR_LBRACKET, "9", "9", "9", "9", ESC_BYTE, "3", "2"};
      send_seq_bytes(1'b1);
      send_byte("k", 1'b0);

      // Random phases with different idle mixes
      run_random(640);
      send_idle = 75;
      rsp_idle  = 23;
      run_random(1260);
      send_idle = 0;
      rsp_idle  = 0;
      // long receiver hold-off while the sender keeps streaming
      hold_req = 1'b1;
      repeat (40) send_byte(8'($urandom_range(32, 126)), 1'b0);
      run_random(1875);
      req_valid <= 1'b0;

      // Drain
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== ansi_sgr_color_parser.f =====
sv/sgr_pkg.sv
sv/sgr_core.sv
sv/ansi_sgr_color_parser.sv
sv/sgr_checker.sv
sim/tb_ansi_sgr_color_parser.sv
